FILE: sv/lph_pkg.sv
package lph_pkg;

   localparam int SLOTS_DEF      = 16;
   localparam int FACE_COUNT_DEF = 4;
   localparam int KEY_W          = 32;
   localparam int EXP_W          = 32;
   localparam int KIND_W         = 2;
   localparam int FACE_W         = 2;
   localparam int STATUS_W       = 3;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   localparam logic [STATUS_W-1:0] RES_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] RES_DELETED  = 3'd1;
   localparam logic [STATUS_W-1:0] RES_FOUND    = 3'd2;
   localparam logic [STATUS_W-1:0] RES_MISSING  = 3'd3;
   localparam logic [STATUS_W-1:0] RES_FULL     = 3'd4;

   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_USED  = 2'd1;
   localparam logic [1:0] SLOT_GONE  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_SEEK,
      ST_PROBE,
      ST_DONE
   } lph_state_type;

endpackage

FILE: sv/lph_if.sv
interface lph_req_if
   import lph_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [KEY_W-1:0]    fingerprint;
   logic [EXP_W-1:0]    expiration;
   logic [FACE_W-1:0]   face;

   modport source (output valid, kind, fingerprint, expiration, face, input ready);
   modport sink   (input valid, kind, fingerprint, expiration, face, output ready);
endinterface

interface lph_rsp_if
   import lph_pkg::*;
   #(parameter int IDX_W = $clog2(SLOTS_DEF))
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    slot_index;

   modport source (output valid, status, slot_index, input ready);
   modport sink   (input valid, status, slot_index, output ready);
endinterface

FILE: sv/linear_probe_hash_table_core.sv
// Flow: a request taken in idle goes through hash and mod (home-slot reduction, only
// when SLOTS is not a power of two), seek and probe (1..SLOTS slots), then done.
// One request at a time: req ready is high only in idle, and done holds the response
// until rsp ready; one slot read per cycle while probing; kind 3 goes straight to done.
// Reset: synchronous, active high; a clearing pass marks every slot
// empty, with req ready low until it ends.
module linear_probe_hash_table_core
   import lph_pkg::*;
   #(
      parameter int SLOTS      = SLOTS_DEF,
      parameter int FACE_COUNT = FACE_COUNT_DEF
   )
   (
      input  logic      clock,
      input  logic      reset,
      lph_req_if.sink   req_chan,
      lph_rsp_if.source rsp_chan
   );

   localparam int   IDX_W = $clog2(SLOTS);
   localparam bit   POW2  = (SLOTS & (SLOTS - 1)) == 0;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W-1:0] SLOTS_LOW = IDX_W'(SLOTS);
   // home slot by reciprocal multiplication: q = (key * RECIP) >> RECIP_SH
   localparam int   RECIP_SH = KEY_W + IDX_W;
   localparam logic [KEY_W:0] RECIP =
      (KEY_W + 1)'(((64'd1 << RECIP_SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

   lph_state_type state_ff, state_in;

   logic [IDX_W-1:0]       clr_ff, clr_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       quo_ff, quo_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [EXP_W-1:0]       exp_ff, exp_in;
   logic [FACE_W-1:0]      face_ff, face_in;
   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   logic [1:0]             status_mem [SLOTS];
   logic [KEY_W-1:0]       key_mem    [SLOTS];
   logic [EXP_W-1:0]       exp_mem    [SLOTS];
   logic [FACE_COUNT-1:0]  mask_mem   [SLOTS];

   logic [1:0]             rd_status_ff;
   logic [KEY_W-1:0]       rd_key_ff;
   logic [IDX_W-1:0]       rd_addr;

   logic                   st_wr_en;
   logic [IDX_W-1:0]       st_wr_addr;
   logic [1:0]             st_wr_data;
   logic                   entry_wr_en;

   logic [IDX_W-1:0]       nxt;
   logic                   last;
   logic [2*KEY_W:0]       recip_prod;
   logic [FACE_COUNT-1:0]  face_mask;

   logic                   probe_end;
   logic [STATUS_W-1:0]    probe_status;
   logic [IDX_W-1:0]       probe_idx;
   logic                   probe_ins;
   logic                   probe_del;

   logic                   req_fire;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign nxt        = (cur_ff == LAST_IDX) ? '0 : cur_ff + 1'b1;
   assign last       = cnt_ff == LAST_IDX;
   assign recip_prod = {{(KEY_W + 1){1'b0}}, key_ff} * {{KEY_W{1'b0}}, RECIP};

   always_comb begin
      for (int i = 0; i < FACE_COUNT; i++) begin
         face_mask[i] = (32'(face_ff) == 32'(i));
      end
   end

   // probe decision on the slot read last cycle (slot cur_ff)
   always_comb begin
      probe_end    = 1'b0;
      probe_status = RES_MISSING;
      probe_idx    = '0;
      probe_ins    = 1'b0;
      probe_del    = 1'b0;
      if (kind_ff == KIND_INSERT) begin
         if (rd_status_ff == SLOT_EMPTY || rd_status_ff == SLOT_GONE) begin
            probe_end    = 1'b1;
            probe_status = RES_INSERTED;
            probe_idx    = cur_ff;
            probe_ins    = 1'b1;
         end else if (last) begin
            probe_end    = 1'b1;
            probe_status = RES_FULL;
         end
      end else begin
         if (rd_status_ff == SLOT_EMPTY) begin
            probe_end = 1'b1;
         end else if (rd_status_ff == SLOT_USED && rd_key_ff == key_ff) begin
            probe_end    = 1'b1;
            probe_idx    = cur_ff;
            if (kind_ff == KIND_DELETE) begin
               probe_status = RES_DELETED;
               probe_del    = 1'b1;
            end else begin
               probe_status = RES_FOUND;
            end
         end else if (last) begin
            probe_end = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == KIND_NONE) state_in = ST_DONE;
               else if (POW2)                  state_in = ST_SEEK;
               else                            state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            state_in = ST_SEEK;
         end
         ST_SEEK: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (probe_end) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_chan.ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and memory controls
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      rd_addr        = cur_ff;
      st_wr_en       = 1'b0;
      st_wr_addr     = cur_ff;
      st_wr_data     = SLOT_EMPTY;
      entry_wr_en    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            st_wr_en   = 1'b1;
            st_wr_addr = clr_ff;
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_SEEK: begin
            rd_addr = cur_ff;
         end
         ST_PROBE: begin
            rd_addr     = nxt;
            st_wr_en    = probe_ins || probe_del;
            st_wr_data  = probe_ins ? SLOT_USED : SLOT_GONE;
            entry_wr_en = probe_ins;
         end
         ST_DONE: begin
            rsp_chan.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.status     = status_ff;
   assign rsp_chan.slot_index = idx_ff;

   // datapath next values
   always_comb begin
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      key_in    = key_ff;
      exp_in    = exp_ff;
      face_in   = face_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      idx_in    = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            key_in    = req_chan.fingerprint;
            exp_in    = req_chan.expiration;
            face_in   = req_chan.face;
            kind_in   = req_chan.kind;
            cur_in    = req_chan.fingerprint[IDX_W-1:0];
            status_in = RES_MISSING;
            idx_in    = '0;
         end
         ST_HASH: begin
            quo_in = recip_prod[RECIP_SH +: IDX_W];
         end
         ST_MOD: begin
            // remainder is below SLOTS, so its low bits are exact
            cur_in = key_ff[IDX_W-1:0] - quo_ff * SLOTS_LOW;
         end
         ST_SEEK: begin
            cnt_in = '0;
         end
         ST_PROBE: begin
            if (probe_end) begin
               status_in = probe_status;
               idx_in    = probe_idx;
            end else begin
               cur_in = nxt;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      cnt_ff    <= cnt_in;
      quo_ff    <= quo_in;
      key_ff    <= key_in;
      exp_ff    <= exp_in;
      face_ff   <= face_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (st_wr_en) status_mem[st_wr_addr] <= st_wr_data;
      rd_status_ff <= status_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (entry_wr_en) begin
         key_mem[cur_ff]  <= key_ff;
         exp_mem[cur_ff]  <= exp_ff;
         mask_mem[cur_ff] <= face_mask;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

endmodule
